// ===== hw/rtl/svpwm_pkg.sv =====
// shared types, register codes and helpers of the svpwm duty calculator
package svpwm_pkg;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_PWM_PERIOD     = 3'd0,
		REG_FULL_SCALE_T   = 3'd1,
		REG_FULL_SCALE_T_S = 3'd2,
		REG_TRIGGER_AFTER  = 3'd3,
		REG_TRIGGER_BEFORE = 3'd4
	} cfg_reg_t;

	// space vector sector numbers
	typedef enum logic [2:0] {
		SEC_1 = 3'd1,
		SEC_2 = 3'd2,
		SEC_3 = 3'd3,
		SEC_4 = 3'd4,
		SEC_5 = 3'd5,
		SEC_6 = 3'd6
	} sector_t;

	// register reset values
	localparam logic [13:0] PWM_PERIOD_RST     = 14'd3600;
	localparam logic [15:0] FULL_SCALE_T_RST   = 16'd14400;
	localparam logic [15:0] FULL_SCALE_T_S_RST = 16'd24941;
	localparam logic [15:0] TRIGGER_AFTER_RST  = 16'd100;
	localparam logic [15:0] TRIGGER_BEFORE_RST = 16'd50;

	// width of the wide signed working values
	localparam int unsigned WIDE_W = 36;

	// shift amounts: halving then dividing by 131072, and dividing by 131072
	localparam int unsigned HALF_DUTY_SHIFT = 18;
	localparam int unsigned DUTY_SHIFT      = 17;

	// signed shift right that rounds toward zero, as a C division by 2^k
	function automatic logic signed [WIDE_W-1:0] trunc_shr(
		input logic signed [WIDE_W-1:0] v,
		input int unsigned              k
	);
		logic signed [WIDE_W-1:0] bias;
		bias = v[WIDE_W-1] ? ((WIDE_W'(1) <<< k) - WIDE_W'(1)) : '0;
		return (v + bias) >>> k;
	endfunction

endpackage

// ===== hw/rtl/svpwm_duty_calculator_unit.sv =====
// space vector pwm duty calculator with three-shunt adc trigger placement
// One alpha/beta voltage demand goes in per transfer and one result comes out:
// the three phase compare values (modulo 65536), the sector (1 to 6), the
// channel four compare value that triggers the adc and its edge polarity.
// The datapath is a six-register pipeline: input register, scaling
// multipliers, x/y/z forming, sector choice and rounding divisions, phase
// compare values, and the result register that also places the trigger.
// An input transfer passes through all six registers before its result is shown;
// one item is taken every cycle as long as results are taken, and each stage
// holds on its own, so empty stages keep filling while a result waits.
// Configuration writes take effect at once and are meant to be made while
// the pipeline is empty.
module svpwm_duty_calculator_unit
	import svpwm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] v_alpha,
	input  logic [15:0] v_beta,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] duty_a,
	output logic [15:0] duty_b,
	output logic [15:0] duty_c,
	output logic [15:0] adc_trigger,
	output logic        trigger_falling,
	output logic [2:0]  sector
);

	// configuration registers
	logic [13:0] pwm_period_q;
	logic [15:0] full_scale_t_q;
	logic [15:0] full_scale_t_sqrt3_q;
	logic [15:0] trigger_after_q;
	logic [15:0] trigger_before_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pwm_period_q         <= PWM_PERIOD_RST;
			full_scale_t_q       <= FULL_SCALE_T_RST;
			full_scale_t_sqrt3_q <= FULL_SCALE_T_S_RST;
			trigger_after_q      <= TRIGGER_AFTER_RST;
			trigger_before_q     <= TRIGGER_BEFORE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PWM_PERIOD:     pwm_period_q         <= cfg_data[13:0];
				REG_FULL_SCALE_T:   full_scale_t_q       <= cfg_data;
				REG_FULL_SCALE_T_S: full_scale_t_sqrt3_q <= cfg_data;
				REG_TRIGGER_AFTER:  trigger_after_q      <= cfg_data;
				REG_TRIGGER_BEFORE: trigger_before_q     <= cfg_data;
				default: ; // indexes beyond the list are ignored
			endcase
		end
	end

	// ------------------------------------------------------------------
	// pipeline flow control: a stage loads when it is empty or its
	// successor loads in the same cycle
	// ------------------------------------------------------------------
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_out;

	assign rdy_out  = !out_valid || out_ready;
	assign rdy_s5   = !vld_s5 || rdy_out;
	assign rdy_s4   = !vld_s4 || rdy_s5;
	assign rdy_s3   = !vld_s3 || rdy_s4;
	assign rdy_s2   = !vld_s2 || rdy_s3;
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			vld_s5    <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (rdy_s1)  vld_s1    <= in_valid;
			if (rdy_s2)  vld_s2    <= vld_s1;
			if (rdy_s3)  vld_s3    <= vld_s2;
			if (rdy_s4)  vld_s4    <= vld_s3;
			if (rdy_s5)  vld_s5    <= vld_s4;
			if (rdy_out) out_valid <= vld_s5;
		end
	end

	// ------------------------------------------------------------------
	// stage 1: input register
	// ------------------------------------------------------------------
	logic signed [15:0] alpha_s1, beta_s1;

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			alpha_s1 <= v_alpha;
			beta_s1  <= v_beta;
		end
	end

	// ------------------------------------------------------------------
	// stage 2: scaling, ua = alpha * T*sqrt3 and ub = -(beta * T)
	// ------------------------------------------------------------------
	logic signed [32:0] prod_a, prod_b;
	logic signed [33:0] ua_s2, ub_s2;

	assign prod_a = alpha_s1 * $signed({1'b0, full_scale_t_sqrt3_q});
	assign prod_b = beta_s1 * $signed({1'b0, full_scale_t_q});

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			ua_s2 <= 34'(prod_a);
			ub_s2 <= -34'(prod_b);
		end
	end

	// ------------------------------------------------------------------
	// stage 3: x = ub, y = (ub + ua)/2, z = (ub - ua)/2, toward zero
	// ------------------------------------------------------------------
	logic signed [WIDE_W-1:0] wx_s3, wy_s3, wz_s3;
	logic signed [WIDE_W-1:0] sum_y, diff_z;

	assign sum_y  = WIDE_W'(ub_s2) + WIDE_W'(ua_s2);
	assign diff_z = WIDE_W'(ub_s2) - WIDE_W'(ua_s2);

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			wx_s3 <= WIDE_W'(ub_s2);
			wy_s3 <= trunc_shr(sum_y, 1);
			wz_s3 <= trunc_shr(diff_z, 1);
		end
	end

	// ------------------------------------------------------------------
	// stage 4: sector choice and the rounding divisions by 2^17 / 2^18
	// ------------------------------------------------------------------
	sector_t                  sector_d, sector_s4;
	logic                     x_le_zero;
	logic signed [WIDE_W-1:0] t_wide, base_sum;
	logic signed [WIDE_W-1:0] qs_wide, qx_wide, qy_wide, qz_wide;
	logic [15:0]              qs_s4, qx_s4, qy_s4, qz_s4;

	assign x_le_zero = wx_s3[WIDE_W-1] || (wx_s3 == '0);
	assign t_wide    = $signed({{(WIDE_W-16){1'b0}}, full_scale_t_q});

	always_comb begin
		if (wy_s3[WIDE_W-1]) begin
			if (wz_s3[WIDE_W-1])  sector_d = SEC_5;
			else if (x_le_zero)   sector_d = SEC_4;
			else                  sector_d = SEC_3;
		end else begin
			if (!wz_s3[WIDE_W-1]) sector_d = SEC_2;
			else if (x_le_zero)   sector_d = SEC_6;
			else                  sector_d = SEC_1;
		end
	end

	// the sum that sets phase a depends on the sector pair
	always_comb begin
		case (sector_d) inside
			SEC_1, SEC_4: base_sum = t_wide + wx_s3 - wz_s3;
			SEC_2, SEC_5: base_sum = t_wide + wy_s3 - wz_s3;
			default:      base_sum = t_wide - wx_s3 + wy_s3;
		endcase
	end

	// halving then dividing by 131072 equals one division by 2^18
	assign qs_wide = trunc_shr(base_sum, HALF_DUTY_SHIFT);
	assign qx_wide = trunc_shr(wx_s3, DUTY_SHIFT);
	assign qy_wide = trunc_shr(wy_s3, DUTY_SHIFT);
	assign qz_wide = trunc_shr(wz_s3, DUTY_SHIFT);

	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			sector_s4 <= sector_d;
			// only the low bits matter, compare values wrap at 2^16
			qs_s4     <= qs_wide[15:0];
			qx_s4     <= qx_wide[15:0];
			qy_s4     <= qy_wide[15:0];
			qz_s4     <= qz_wide[15:0];
		end
	end

	// ------------------------------------------------------------------
	// stage 5: phase compare values, main phase and its neighbour
	// ------------------------------------------------------------------
	logic [15:0] a_d, b_d, c_d, m_d, o_d;
	logic [15:0] a_s5, b_s5, c_s5, m_s5, o_s5;
	sector_t     sector_s5;

	assign a_d = {3'b000, full_scale_t_q[15:3]} + qs_s4;

	always_comb begin
		case (sector_s4) inside
			SEC_1, SEC_4: begin
				b_d = a_d + qz_s4;
				c_d = b_d - qx_s4;
			end
			SEC_2, SEC_5: begin
				b_d = a_d + qz_s4;
				c_d = a_d - qy_s4;
			end
			default: begin
				c_d = a_d - qy_s4;
				b_d = c_d + qx_s4;
			end
		endcase
	end

	always_comb begin
		unique case (sector_s4)
			SEC_1:   begin m_d = a_d; o_d = b_d; end
			SEC_2:   begin m_d = b_d; o_d = a_d; end
			SEC_3:   begin m_d = b_d; o_d = c_d; end
			SEC_4:   begin m_d = c_d; o_d = b_d; end
			SEC_5:   begin m_d = c_d; o_d = a_d; end
			default: begin m_d = a_d; o_d = c_d; end
		endcase
	end

	always_ff @(posedge clk) begin
		if (rdy_s5) begin
			a_s5      <= a_d;
			b_s5      <= b_d;
			c_s5      <= c_d;
			m_s5      <= m_d;
			o_s5      <= o_d;
			sector_s5 <= sector_s4;
		end
	end

	// ------------------------------------------------------------------
	// result stage: adc trigger placement
	// ------------------------------------------------------------------
	logic [15:0] period16, room, delta, trig_d, after_pt, mirrored;
	logic [16:0] room_x2;
	logic        falling_d;

	assign period16 = {2'b00, pwm_period_q};
	assign room     = period16 - m_s5;
	assign delta    = m_s5 - o_s5;
	assign room_x2  = {room, 1'b0};
	assign after_pt = m_s5 + trigger_after_q;
	// mirror a point past the period back into the down-count half
	assign mirrored = {period16[14:0], 1'b0} - after_pt - 16'd1;

	always_comb begin
		falling_d = 1'b0;
		if (room > trigger_after_q) begin
			// widest phase leaves room, sample just before the period
			trig_d = period16 - 16'd1;
		end else if ({1'b0, delta} > room_x2) begin
			// sample before the crossing point
			trig_d = m_s5 - trigger_before_q;
		end else if (after_pt >= period16) begin
			trig_d    = mirrored;
			falling_d = 1'b1;
		end else begin
			trig_d = after_pt;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_out) begin
			duty_a          <= a_s5;
			duty_b          <= b_s5;
			duty_c          <= c_s5;
			adc_trigger     <= trig_d;
			trigger_falling <= falling_d;
			sector          <= sector_s5;
		end
	end

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	a_sector_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (sector >= 3'd1 && sector <= 3'd6))
		else $error("sector out of range on result");

	a_drain_opens_input: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready) |-> in_ready)
		else $error("input stalled while the result transfer frees the pipeline");

	a_stall_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (vld_s1 && vld_s2 && vld_s3 && vld_s4 && vld_s5 && out_valid))
		else $error("input stalled with an empty stage");

	a_last_stage_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s5 && !out_valid) |=> out_valid)
		else $error("item in last stage did not reach the result register");

endmodule

// ===== sim/tb_svpwm_duty_calculator_unit.sv =====
// testbench of the svpwm duty calculator: self-checking, random and directed voltage vectors
module tb_svpwm_duty_calculator_unit
	import svpwm_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	// pipeline depth given at the head of the block, plus a little margin for draining
	localparam int PIPE_LATENCY = 6;
	localparam int DRAIN_CYCLES = PIPE_LATENCY + 2;
	// cycles without any transfer before the run is declared hung
	localparam int QUIET_LIMIT  = 2000;
	// length of the deliberate receiver hold-off that backs the pipeline up
	localparam int LONG_HOLD    = 80;
	// divisor that turns the wide products into timer ticks
	localparam longint DUTY_DIV = 131072;
	// register indexes past the end of the map, writes to these are dropped
	localparam logic [2:0] FIRST_UNMAPPED = 3'd5;
	localparam logic [2:0] LAST_UNMAPPED  = 3'd7;
	localparam int N_DIRECTED = 24;
	localparam int N_RANDOM   = 85;

	typedef struct {
		logic [15:0] alpha;
		logic [15:0] beta;
	} volt_vector_t;

	typedef struct {
		logic [15:0] duty_a;
		logic [15:0] duty_b;
		logic [15:0] duty_c;
		logic [15:0] adc_trigger;
		logic        trigger_falling;
		sector_t     sector;
	} duty_result_t;

	// clock, reset and every block input start at known values
	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [2:0]  cfg_index = REG_PWM_PERIOD;
	logic [15:0] cfg_data  = '0;
	logic        in_valid  = 1'b0;
	logic [15:0] v_alpha   = '0;
	logic [15:0] v_beta    = '0;
	logic        out_ready = 1'b0;

	logic        in_ready;
	logic        out_valid;
	logic [15:0] duty_a;
	logic [15:0] duty_b;
	logic [15:0] duty_c;
	logic [15:0] adc_trigger;
	logic        trigger_falling;
	logic [2:0]  sector;

	// testbench copy of the register file, kept in step with every write
	logic [13:0] cfg_period  = PWM_PERIOD_RST;
	logic [15:0] cfg_t       = FULL_SCALE_T_RST;
	logic [15:0] cfg_t_sqrt3 = FULL_SCALE_T_S_RST;
	logic [15:0] cfg_after   = TRIGGER_AFTER_RST;
	logic [15:0] cfg_before  = TRIGGER_BEFORE_RST;

	volt_vector_t vector_queue[$];   // vectors waiting to be offered
	duty_result_t duty_expected[$];  // predicted results, oldest first

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int stall_orders  = 0;
	int stall_served  = 0;
	int hold_left     = 0;
	int quiet_cycles  = 0;
	int mismatches    = 0;

	// directed vectors: field extremes, sign corners, one per sector, and a handful
	// that put the main phase just under the period so the trigger is moved
	int dir_pairs [N_DIRECTED][2] = '{
		'{0, 0}, '{32767, 32767}, '{-32768, -32768}, '{32767, -32768},
		'{-32768, 32767}, '{32767, 0}, '{-32768, 0}, '{0, 32767},
		'{0, -32768}, '{1, 1}, '{-1, -1}, '{1, -1}, '{-1, 1},
		'{20000, 0}, '{10000, 17320}, '{-10000, 17320}, '{-20000, 0},
		'{-10000, -17320}, '{10000, -17320},
		'{32767, -6990}, '{28000, -16000}, '{30000, -12000}, '{26000, -15000},
		'{32767, -9000}
	};

	svpwm_duty_calculator_unit i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.v_alpha         (v_alpha),
		.v_beta          (v_beta),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.duty_a          (duty_a),
		.duty_b          (duty_b),
		.duty_c          (duty_c),
		.adc_trigger     (adc_trigger),
		.trigger_falling (trigger_falling),
		.sector          (sector)
	);

	always #5 clk = ~clk;

	// duty and trigger prediction for one alpha/beta demand under the current registers
	function automatic duty_result_t calc_duty_result(
		input logic signed [15:0] alpha,
		input logic signed [15:0] beta
	);
		longint       t;
		longint       ua;
		longint       ub;
		longint       wx;
		longint       wy;
		longint       wz;
		logic [15:0]  a;
		logic [15:0]  b;
		logic [15:0]  c;
		logic [15:0]  m;
		logic [15:0]  o;
		logic [31:0]  p;
		logic [31:0]  room;
		logic [31:0]  delta;
		logic [31:0]  d;
		logic         falling;
		sector_t      sec;
		duty_result_t r;
		t  = longint'(cfg_t);
		ua = longint'(alpha) * longint'(cfg_t_sqrt3);
		ub = -(longint'(beta) * t);
		// x, y, z with signed halving that truncates toward zero
		wx = ub;
		wy = (ub + ua) / 2;
		wz = (ub - ua) / 2;
		if (wy < 0) begin
			sec = (wz < 0) ? SEC_5 : ((wx <= 0) ? SEC_4 : SEC_3);
		end else begin
			sec = (wz >= 0) ? SEC_2 : ((wx <= 0) ? SEC_6 : SEC_1);
		end
		case (sec)
			SEC_1, SEC_4: begin
				a = 16'(t / 8 + ((t + wx - wz) / 2) / DUTY_DIV);
				b = 16'(longint'(a) + wz / DUTY_DIV);
				c = 16'(longint'(b) - wx / DUTY_DIV);
			end
			SEC_2, SEC_5: begin
				a = 16'(t / 8 + ((t + wy - wz) / 2) / DUTY_DIV);
				b = 16'(longint'(a) + wz / DUTY_DIV);
				c = 16'(longint'(a) - wy / DUTY_DIV);
			end
			default: begin
				a = 16'(t / 8 + ((t - wx + wy) / 2) / DUTY_DIV);
				c = 16'(longint'(a) - wy / DUTY_DIV);
				b = 16'(longint'(c) + wx / DUTY_DIV);
			end
		endcase
		// main phase and its neighbour for trigger placement
		case (sec)
			SEC_1:   begin m = a; o = b; end
			SEC_2:   begin m = b; o = a; end
			SEC_3:   begin m = b; o = c; end
			SEC_4:   begin m = c; o = b; end
			SEC_5:   begin m = c; o = a; end
			default: begin m = a; o = c; end
		endcase
		p       = 32'(cfg_period);
		falling = 1'b0;
		room    = (p - 32'(m)) & 32'hFFFF;
		if (room > 32'(cfg_after)) begin
			d = (p - 32'd1) & 32'hFFFF;
		end else begin
			delta = (32'(m) - 32'(o)) & 32'hFFFF;
			if (delta > room * 32'd2) begin
				d = (32'(m) - 32'(cfg_before)) & 32'hFFFF;
			end else begin
				d = (32'(m) + 32'(cfg_after)) & 32'hFFFF;
				if (d >= p) begin
					// mirrored back from the period, sampled on the down-count
					falling = 1'b1;
					d       = (32'd2 * p - d - 32'd1) & 32'hFFFF;
				end
			end
		end
		r.duty_a          = a;
		r.duty_b          = b;
		r.duty_c          = c;
		r.adc_trigger     = d[15:0];
		r.trigger_falling = falling;
		r.sector          = sec;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	// one register write; the block is idle whenever this is called
	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_PWM_PERIOD:     cfg_period  = 14'(val);
			REG_FULL_SCALE_T:   cfg_t       = val;
			REG_FULL_SCALE_T_S: cfg_t_sqrt3 = val;
			REG_TRIGGER_AFTER:  cfg_after   = val;
			REG_TRIGGER_BEFORE: cfg_before  = val;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic write_all_regs(
		input logic [15:0] period,
		input logic [15:0] scale,
		input logic [15:0] scale_sqrt3,
		input logic [15:0] after,
		input logic [15:0] before_ticks
	);
		write_reg(REG_PWM_PERIOD, period);
		write_reg(REG_FULL_SCALE_T, scale);
		write_reg(REG_FULL_SCALE_T_S, scale_sqrt3);
		write_reg(REG_TRIGGER_AFTER, after);
		write_reg(REG_TRIGGER_BEFORE, before_ticks);
	endtask

	// wait until every vector has gone through and been checked, then let the pipe settle
	task automatic wait_drained();
		do begin
			@(negedge clk);
		end while (vector_queue.size() != 0 || in_valid || duty_expected.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// mix of full-range noise, bounded magnitudes and field corners
	task automatic queue_random_vectors(input int n);
		int          i;
		int          lim;
		int          kind;
		logic [15:0] al;
		logic [15:0] be;
		logic [15:0] corner [5];
		corner = '{16'h8000, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFF};
		for (i = 0; i < n; i++) begin
			kind = $urandom_range(9);
			if (kind < 4) begin
				al = 16'($urandom);
				be = 16'($urandom);
			end else if (kind < 9) begin
				case ($urandom_range(2))
					0: lim = 2000;
					1: lim = 20000;
					default: lim = 32767;
				endcase
				al = 16'(int'($urandom_range(2 * lim)) - lim);
				be = 16'(int'($urandom_range(2 * lim)) - lim);
			end else begin
				al = corner[$urandom_range(4)];
				be = corner[$urandom_range(4)];
			end
			vector_queue.push_back('{alpha: al, beta: be});
		end
	endtask

	// driver: offers queued vectors, holds each one steady until its transfer
	always @(posedge clk) begin
		logic         took;
		volt_vector_t next_vec;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			took = in_valid && in_ready;
			if (took) begin
				duty_expected.push_back(calc_duty_result(v_alpha, v_beta));
			end
			if (in_valid && !took) begin
				// still waiting, payload stays put
			end else if (vector_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_vec = vector_queue.pop_front();
				in_valid <= 1'b1;
				v_alpha  <= next_vec.alpha;
				v_beta   <= next_vec.beta;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: random back-pressure, plus a long hold-off when one is ordered
	always @(posedge clk) begin
		if (stall_orders != stall_served) begin
			stall_served = stall_orders;
			hold_left    = LONG_HOLD;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// monitor: each result transfer against the oldest prediction
	always @(posedge clk) begin
		duty_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (duty_expected.size() == 0) begin
				mismatches++;
				$display("%0t: result with nothing expected, expected none, actual a=%0d b=%0d c=%0d",
					$time, duty_a, duty_b, duty_c);
			end else begin
				want = duty_expected.pop_front();
				check_field("duty_a", want.duty_a, duty_a);
				check_field("duty_b", want.duty_b, duty_b);
				check_field("duty_c", want.duty_c, duty_c);
				check_field("adc_trigger", want.adc_trigger, adc_trigger);
				check_field("trigger_falling", 16'(want.trigger_falling), 16'(trigger_falling));
				check_field("sector", 16'(want.sector), 16'(sector));
			end
		end
	end

	// watchdog: ends a run that stops making progress
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int i;
		int per;
		int scale;
		// sender idles lightly, receiver heavily
		send_idle_pct = 19;
		recv_idle_pct = 51;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed vectors under the reset register values
		for (i = 0; i < N_DIRECTED; i++) begin
			vector_queue.push_back('{alpha: 16'(dir_pairs[i][0]), beta: 16'(dir_pairs[i][1])});
		end
		wait_drained();

		// largest period and scales, trigger offsets at zero
		write_all_regs(16'd16383, 16'd65535, 16'd65535, 16'd0, 16'd0);
		queue_random_vectors(N_RANDOM);
		wait_drained();

		// roles swapped: sender idles heavily, receiver lightly
		send_idle_pct = 51;
		recv_idle_pct = 19;
		// smallest period, small scales, offsets at their maximum, so the trigger
		// is never placed just before the period
		write_all_regs(16'd1, 16'd4, 16'd7, 16'hFFFF, 16'hFFFF);
		write_reg(FIRST_UNMAPPED, 16'hA5A5);
		write_reg(LAST_UNMAPPED, 16'h5A5A);
		queue_random_vectors(N_RANDOM);
		wait_drained();

		// period written with only the top bits set, masking leaves zero
		write_all_regs(16'hC000, 16'd8000, 16'd13856, 16'd1500, 16'd700);
		queue_random_vectors(N_RANDOM);
		wait_drained();

		// no idling on either side, with one long receiver hold-off to fill the pipe
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_all_regs(16'd3600, 16'd14400, 16'd24941, 16'd1500, 16'd400);
		queue_random_vectors(N_RANDOM);
		stall_orders++;
		wait_drained();

		// a random but consistent machine setting
		per   = $urandom_range(16383, 1);
		scale = (4 * per) & 16'hFFFF;
		write_all_regs(16'(per), 16'(scale), 16'((scale * 1732) / 1000),
			16'($urandom_range(3000)), 16'($urandom_range(3000)));
		write_reg(3'($urandom_range(LAST_UNMAPPED, FIRST_UNMAPPED)), 16'($urandom));
		queue_random_vectors(N_RANDOM);
		wait_drained();

		if (mismatches == 0 && duty_expected.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
